>>> rtl/core/set_of_stacks_engine_unit_defines.svh
// Assertion macros shared by the set-of-stacks engine modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef SET_OF_STACKS_ENGINE_UNIT_DEFINES_SVH
`define SET_OF_STACKS_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sos_pkg.sv
// Shared types and constants of the set-of-stacks engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package sos_pkg;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_TOP   = 2'd2;
   localparam logic [1:0] OP_POPAT = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [4:0]  CAPACITY_RESET = 5'd10;
   localparam logic [31:0] WORD_MIN       = 32'h8000_0000;

   localparam int          CSR_ADDR_W        = 2;
   localparam logic [1:0]  CSR_CAPACITY_ADDR = 2'd0;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] push_value;
      logic [3:0]         stack_index;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
   } rsp_data_type;

   typedef struct packed {
      logic       latch_req;
      logic       fill_rd;
      logic       fill_rd_idx;
      logic       cur_inc;
      logic       cur_dec;
      logic       fill_wr_inc;
      logic       fill_wr_dec;
      logic       word_wr;
      logic       word_rd;
      logic       set_result;
      logic [1:0] result_status;
      logic       result_min;
      logic       result_word;
      logic       load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic [1:0] op;
      logic       fill_full;
      logic       fill_zero;
      logic       cur_zero;
      logic       cur_last;
      logic       idx_range;
      logic       rsp_busy;
   } ctl_sts_type;

endpackage

>>> rtl/core/sos_ctrl.sv
// Controller of the set-of-stacks engine: sequences each item through the
// fill-count read, an optional step to a neighbor sub-stack and a store read or write.
// Depends on sos_pkg and the assertion macros header.
`include "set_of_stacks_engine_unit_defines.svh"

module sos_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sos_pkg::ctl_sts_type sts,
   output sos_pkg::ctl_cmd_type cmd
);
   import sos_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FILL  = 5'b00010,
      S_FILL2 = 5'b00100,
      S_WORD  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch_req   = 1'b1;
               cmd.fill_rd     = 1'b1;
               cmd.fill_rd_idx = (sts.req_op == OP_POPAT);
               state_in        = S_FILL;
            end
         end
         S_FILL: begin
            case (sts.op) inside
               OP_PUSH: begin
                  if (sts.fill_full) begin
                     if (sts.cur_last) begin
                        cmd.set_result    = 1'b1;
                        cmd.result_status = ST_FULL;
                        state_in          = S_DONE;
                     end else begin
                        cmd.cur_inc = 1'b1;
                        cmd.fill_rd = 1'b1;
                        state_in    = S_FILL2;
                     end
                  end else begin
                     cmd.word_wr       = 1'b1;
                     cmd.fill_wr_inc   = 1'b1;
                     cmd.set_result    = 1'b1;
                     cmd.result_status = ST_OK;
                     state_in          = S_DONE;
                  end
               end
               OP_POP, OP_TOP: begin
                  if (sts.fill_zero) begin
                     if (sts.cur_zero) begin
                        cmd.set_result    = 1'b1;
                        cmd.result_status = ST_EMPTY;
                        cmd.result_min    = (sts.op == OP_TOP);
                        state_in          = S_DONE;
                     end else begin
                        cmd.cur_dec = 1'b1;
                        cmd.fill_rd = 1'b1;
                        state_in    = S_FILL2;
                     end
                  end else if (sts.op == OP_POP) begin
                     cmd.fill_wr_dec   = 1'b1;
                     cmd.set_result    = 1'b1;
                     cmd.result_status = ST_OK;
                     state_in          = S_DONE;
                  end else begin
                     cmd.word_rd = 1'b1;
                     state_in    = S_WORD;
                  end
               end
               default: begin
                  cmd.set_result = 1'b1;
                  if (sts.idx_range) begin
                     cmd.result_status = ST_RANGE;
                  end else if (sts.fill_zero) begin
                     cmd.result_status = ST_EMPTY;
                  end else begin
                     cmd.fill_wr_dec   = 1'b1;
                     cmd.result_status = ST_OK;
                  end
                  state_in = S_DONE;
               end
            endcase
         end
         S_FILL2: begin
            if (sts.op == OP_PUSH) begin
               cmd.word_wr       = 1'b1;
               cmd.fill_wr_inc   = 1'b1;
               cmd.set_result    = 1'b1;
               cmd.result_status = ST_OK;
               state_in          = S_DONE;
            end else if (sts.fill_zero) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = ST_EMPTY;
               cmd.result_min    = (sts.op == OP_TOP);
               state_in          = S_DONE;
            end else if (sts.op == OP_POP) begin
               cmd.fill_wr_dec   = 1'b1;
               cmd.set_result    = 1'b1;
               cmd.result_status = ST_OK;
               state_in          = S_DONE;
            end else begin
               cmd.word_rd = 1'b1;
               state_in    = S_WORD;
            end
         end
         S_WORD: begin
            cmd.set_result    = 1'b1;
            cmd.result_status = ST_OK;
            cmd.result_word   = 1'b1;
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SOS_ASSERT_NEXT(a_accept_to_fill, clock, reset, accept, state_ff == S_FILL, "item accepted without fill read")
   `SOS_ASSERT_NEXT(a_step_to_fill2, clock, reset, cmd.cur_inc || cmd.cur_dec, state_ff == S_FILL2, "pointer step without second fill read")

endmodule

>>> rtl/core/sos_dpath.sv
// Datapath of the set-of-stacks engine: fill-count memory, word store,
// stack pointers, capacity register and the result output register.
// Depends on sos_pkg and the assertion macros header.
`include "set_of_stacks_engine_unit_defines.svh"

module sos_dpath #(
   parameter int MAX_STACKS = 16,
   parameter int SUB_DEPTH  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sos_pkg::req_data_type                  req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output sos_pkg::rsp_data_type                  rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [sos_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   input  sos_pkg::ctl_cmd_type                   cmd,
   output sos_pkg::ctl_sts_type                   sts
);
   import sos_pkg::*;

   localparam int CUR_W   = $clog2(MAX_STACKS);
   localparam int CNT_W   = $clog2(SUB_DEPTH + 1);
   localparam int SLOT_W  = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;
   localparam int ALLOC_W = $clog2(MAX_STACKS + 1);
   localparam int WORD_N  = MAX_STACKS * SUB_DEPTH;
   localparam int WORD_AW = $clog2(WORD_N);
   localparam int CMP_W   = (CNT_W > 5) ? CNT_W : 5;
   localparam int RNG_W   = (ALLOC_W > 4) ? ALLOC_W : 4;

   logic [CUR_W-1:0]   cur_ff, cur_in;
   logic [ALLOC_W-1:0] alloc_ff, alloc_in;
   logic [4:0]         cap_ff, cap_in;
   logic [1:0]         op_ff;
   logic [31:0]        value_ff;
   logic [3:0]         idx_ff;

   logic [CNT_W-1:0]   fill_mem_ff [MAX_STACKS];
   logic [MAX_STACKS-1:0] fill_vld_ff, fill_vld_in;
   logic [CNT_W-1:0]   fill_rd_ff;
   logic               fill_rd_vld_ff;
   logic [31:0]        word_mem_ff [WORD_N];
   logic [31:0]        word_rd_ff;

   logic [31:0]        res_value_ff;
   logic [1:0]         res_status_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff;

   logic [CNT_W-1:0]   fill_q;
   logic [CUR_W-1:0]   fill_rd_addr;
   logic [CUR_W-1:0]   fill_wr_addr;
   logic [CNT_W-1:0]   fill_wr_data;
   logic               fill_wr_en;
   logic [CMP_W-1:0]   cap_eff;
   logic [SLOT_W-1:0]  word_slot;
   logic [WORD_AW-1:0] word_addr;
   logic               cfg_wr;

   assign fill_q = fill_rd_vld_ff ? fill_rd_ff : '0;

   always_comb begin
      if (cap_ff == 5'd0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(SUB_DEPTH)) begin
         cap_eff = CMP_W'(SUB_DEPTH);
      end else begin
         cap_eff = CMP_W'(cap_ff);
      end
   end

   always_comb begin
      cur_in   = cur_ff;
      alloc_in = alloc_ff;
      if (cmd.cur_inc) begin
         cur_in   = cur_ff + CUR_W'(1);
         alloc_in = ALLOC_W'(cur_ff) + ALLOC_W'(2);
      end else if (cmd.cur_dec) begin
         cur_in = cur_ff - CUR_W'(1);
      end
   end

   assign fill_rd_addr = cmd.fill_rd_idx ? CUR_W'(req_data.stack_index) : cur_in;
   assign fill_wr_addr = (op_ff == OP_POPAT) ? CUR_W'(idx_ff) : cur_ff;
   assign fill_wr_en   = cmd.fill_wr_inc || cmd.fill_wr_dec;
   assign fill_wr_data = cmd.fill_wr_inc ? (fill_q + CNT_W'(1)) : (fill_q - CNT_W'(1));

   always_comb begin
      fill_vld_in = fill_vld_ff;
      if (fill_wr_en) begin
         fill_vld_in[fill_wr_addr] = 1'b1;
      end
   end

   assign word_slot = cmd.word_wr ? SLOT_W'(fill_q) : SLOT_W'(fill_q - CNT_W'(1));
   assign word_addr = WORD_AW'(cur_ff) * WORD_AW'(SUB_DEPTH) + WORD_AW'(word_slot);

   assign cfg_wr = psel && penable && pwrite && (paddr == CSR_CAPACITY_ADDR);
   assign cap_in = cfg_wr ? pwdata[4:0] : cap_ff;
   assign prdata = (paddr == CSR_CAPACITY_ADDR) ? 32'(cap_ff) : 32'd0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff         <= '0;
         alloc_ff       <= ALLOC_W'(1);
         cap_ff         <= CAPACITY_RESET;
         fill_vld_ff    <= '0;
         fill_rd_vld_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         alloc_ff     <= alloc_in;
         cap_ff       <= cap_in;
         fill_vld_ff  <= fill_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.fill_rd) begin
            fill_rd_vld_ff <= fill_vld_ff[fill_rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= req_data.opcode;
         value_ff <= req_data.push_value;
         idx_ff   <= req_data.stack_index;
      end
      if (fill_wr_en) begin
         fill_mem_ff[fill_wr_addr] <= fill_wr_data;
      end
      if (cmd.fill_rd) begin
         fill_rd_ff <= fill_mem_ff[fill_rd_addr];
      end
      if (cmd.word_wr) begin
         word_mem_ff[word_addr] <= value_ff;
      end
      if (cmd.word_rd) begin
         word_rd_ff <= word_mem_ff[word_addr];
      end
      if (cmd.set_result) begin
         res_status_ff <= cmd.result_status;
         if (cmd.result_word) begin
            res_value_ff <= word_rd_ff;
         end else if (cmd.result_min) begin
            res_value_ff <= WORD_MIN;
         end else begin
            res_value_ff <= 32'd0;
         end
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.read_value <= res_value_ff;
         rsp_data_ff.status     <= res_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.req_op    = req_data.opcode;
   assign sts.op        = op_ff;
   assign sts.fill_full = (CMP_W'(fill_q) >= cap_eff);
   assign sts.fill_zero = (fill_q == '0);
   assign sts.cur_zero  = (cur_ff == '0);
   assign sts.cur_last  = (cur_ff == CUR_W'(MAX_STACKS - 1));
   assign sts.idx_range = (RNG_W'(idx_ff) >= RNG_W'(alloc_ff))
                       || (RNG_W'(idx_ff) >= RNG_W'(MAX_STACKS));
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;

   `SOS_ASSERT_NOW(a_cur_below_alloc, clock, reset, 1'b1, ALLOC_W'(cur_ff) < alloc_ff, "current sub-stack not allocated")
   `SOS_ASSERT_NOW(a_no_rsp_overwrite, clock, reset, cmd.load_rsp, !(rsp_valid_ff && rsp_stall), "waiting item overwritten")
   `SOS_ASSERT_NOW(a_fill_bound, clock, reset, fill_wr_en, fill_wr_data <= CNT_W'(SUB_DEPTH), "fill count beyond depth")

endmodule

>>> rtl/core/set_of_stacks_engine_unit.sv
// Top level of the set-of-stacks engine: several bounded sub-stacks that act as one stack.
// Instantiates sos_ctrl and sos_dpath; depends on sos_pkg.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_data (opcode, push_value, stack_index)
//   rsp_      out        rsp_valid/rsp_stall  rsp_data (read_value, status)
//   APB       in/out     psel/penable/pready  sub_capacity at address 0
//
// An item steps through S_FILL and S_DONE; top adds S_WORD, and passing over the
// current sub-stack adds S_FILL2; the registered fill-count read sets this.
// Reset is synchronous; fill counts clear at once through per-entry valid flags.
// req_stall is high while an item is in work; a finished result waits in the
// output register, and the next item is taken while it waits.
module set_of_stacks_engine_unit #(
   parameter int MAX_STACKS = 16,
   parameter int SUB_DEPTH  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sos_pkg::req_data_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sos_pkg::rsp_data_type          rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sos_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import sos_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign pready = 1'b1;

   sos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sos_dpath #(
      .MAX_STACKS (MAX_STACKS),
      .SUB_DEPTH  (SUB_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for set_of_stacks_engine_unit: push, pop, top and pop-at items run
// through a behavioral set-of-stacks model, and every result item is compared with it.
// Depends on sos_pkg and the engine RTL.
module testbench;
   import sos_pkg::*;

   localparam int NUM_STACKS  = 16;
   localparam int STACK_DEPTH = 16;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_data_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_data_type          rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   set_of_stacks_engine_unit #(
      .MAX_STACKS(NUM_STACKS),
      .SUB_DEPTH (STACK_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   logic [31:0] word_mem [NUM_STACKS][STACK_DEPTH];
   logic [4:0]  depth_of [NUM_STACKS];
   int          cur_stack;
   int          live_stacks;
   logic [4:0]  capacity;

   req_data_type queued_requests[$];
   rsp_data_type pending_results[$];
   int           errors         = 0;
   int           results_seen   = 0;
   bit           sender_idles   = 1'b0;
   bit           receiver_idles = 1'b0;
   int           send_wait      = 0;
   int           recv_wait      = 0;
   int           long_hold      = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(400000 * 12);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int draw_wait(bit gappy);
      if (!gappy || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic rsp_data_type stack_predict(req_data_type r);
      rsp_data_type res;
      int           lim;
      res.read_value = '0;
      res.status     = ST_OK;
      lim = (capacity == 0) ? 1 : ((capacity > STACK_DEPTH) ? STACK_DEPTH : capacity);
      case (r.opcode)
         OP_PUSH: begin
            if (depth_of[cur_stack] >= lim) begin
               if (cur_stack + 1 >= NUM_STACKS) begin
                  res.status = ST_FULL;
               end else begin
                  cur_stack++;
                  live_stacks = cur_stack + 1;
               end
            end
            if (res.status == ST_OK) begin
               word_mem[cur_stack][depth_of[cur_stack]] = r.push_value;
               depth_of[cur_stack]++;
            end
         end
         OP_POP, OP_TOP: begin
            if (depth_of[cur_stack] == 0 && cur_stack > 0) cur_stack--;
            if (depth_of[cur_stack] == 0) begin
               res.status = ST_EMPTY;
               if (r.opcode == OP_TOP) res.read_value = WORD_MIN;
            end else if (r.opcode == OP_POP) begin
               depth_of[cur_stack]--;
            end else begin
               res.read_value = word_mem[cur_stack][depth_of[cur_stack] - 1];
            end
         end
         default: begin
            if (r.stack_index >= live_stacks) res.status = ST_RANGE;
            else if (depth_of[r.stack_index] == 0) res.status = ST_EMPTY;
            else depth_of[r.stack_index]--;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && !req_stall) pending_results.push_back(stack_predict(req_data));
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
               req_data  <= queued_requests.pop_front();
               req_valid <= 1'b1;
               send_wait <= draw_wait(sender_idles);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_data_type want;
      int           w;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
         long_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result item, read_value %h status %0d", $time,
                     rsp_data.read_value, rsp_data.status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                        rsp_data.read_value);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
               errors++;
            end
         end
         if (results_seen == 500) begin
            long_hold <= 90;
            rsp_stall <= 1'b1;
         end else begin
            w = draw_wait(receiver_idles);
            recv_wait <= w;
            rsp_stall <= (w != 0);
         end
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_stall <= (long_hold > 1);
      end else if (recv_wait > 0) begin
         recv_wait <= recv_wait - 1;
         rsp_stall <= (recv_wait > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_item(logic [1:0] op, logic [31:0] value, logic [3:0] idx);
      req_data_type r;
      r.opcode      = op;
      r.push_value  = value;
      r.stack_index = idx;
      queued_requests.push_back(r);
   endtask

   task automatic queue_random(int count, int push_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < push_pct)
            queue_item(OP_PUSH, $urandom, 4'($urandom_range(0, 15)));
         else
            queue_item(2'($urandom_range(1, 3)), $urandom, 4'($urandom_range(0, 15)));
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || pending_results.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [4:0] cap);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_CAPACITY_ADDR;
      pwdata  <= {27'($urandom), cap};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      capacity = cap;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      if (prdata[4:0] !== cap) begin
         $display("%0t: sub_capacity expected %0d actual %0d", $time, cap, prdata[4:0]);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int          caps [7];
      int          push_pct [7];
      for (int i = 0; i < NUM_STACKS; i++) depth_of[i] = '0;
      cur_stack   = 0;
      live_stacks = 1;
      capacity    = CAPACITY_RESET;
      caps     = '{16, 0, 31, 2, 0, 1, 10};
      push_pct = '{70, 40, 65, 75, 50, 80, 35};
      caps[4]  = $urandom_range(0, 31);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      queue_item(OP_TOP, $urandom, 4'd0);
      queue_item(OP_POP, $urandom, 4'd0);
      queue_item(OP_POPAT, $urandom, 4'd0);
      queue_item(OP_POPAT, $urandom, 4'd15);
      queue_item(OP_POPAT, $urandom, 4'd1);
      queue_item(OP_PUSH, 32'h7fff_ffff, 4'd0);
      queue_item(OP_PUSH, 32'h8000_0000, 4'd15);
      queue_item(OP_TOP, $urandom, 4'd0);
      queue_item(OP_POP, $urandom, 4'd0);
      queue_item(OP_TOP, $urandom, 4'd0);
      queue_item(OP_POP, $urandom, 4'd0);
      queue_item(OP_PUSH, 32'h0000_0000, 4'd0);
      queue_item(OP_PUSH, 32'hffff_ffff, 4'd0);
      queue_item(OP_TOP, $urandom, 4'd0);
      wait_drained();

      // With a capacity of one, pushes spread over sub-stacks; a pop-at then leaves a hole.
      csr_write(5'd1);
      @(negedge clock);
      queue_item(OP_PUSH, 32'h1234_5678, 4'd0);
      queue_item(OP_PUSH, 32'h5a5a_a5a5, 4'd0);
      queue_item(OP_POPAT, $urandom, 4'd1);
      queue_item(OP_POP, $urandom, 4'd0);
      queue_item(OP_POP, $urandom, 4'd0);
      queue_item(OP_TOP, $urandom, 4'd0);
      queue_item(OP_PUSH, $urandom, 4'd0);
      queue_item(OP_POPAT, $urandom, 4'd2);
      wait_drained();

      for (int p = 0; p < 7; p++) begin
         csr_write(5'(caps[p]));
         sender_idles   = (p % 3 != 0);
         receiver_idles = (p % 3 != 1);
         @(negedge clock);
         queue_random(150, push_pct[p]);
         wait_drained();
      end

      repeat (12) @(negedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sos_pkg.sv
rtl/core/sos_ctrl.sv
rtl/core/sos_dpath.sv
rtl/core/set_of_stacks_engine_unit.sv
verif/testbench.sv
